// File: design/vfd_pkg.sv
// Shared types and codes for the VADPCM frame decoder.
// Used by vfd_mac_engine and vadpcm_frame_decoder_unit; depends on nothing.
`timescale 1ns / 1ps

package vfd_pkg;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic REG_NUM_PRED = 1'b0;

  localparam logic [3:0] FRAME_DATA_BYTES = 4'd8;

  typedef enum logic [1:0] {
    E_IDLE,
    E_RUN,
    E_DRAIN,
    E_DONE
  } eng_state_t;

  // Commands from the frame control into the MAC engine.
  typedef struct packed {
    logic               start;
    logic [2:0]         j_base;
    logic [3:0]         pred;
    logic signed [15:0] prev_one;
    logic signed [15:0] prev_two;
    logic               nib_we;
    logic [1:0]         pair;
    logic signed [15:0] nib_hi;
    logic signed [15:0] nib_lo;
    logic               cb_we;
    logic [7:0]         cb_addr;
    logic [15:0]        cb_data;
  } vfd_ctl_t;

  // One finished sample waiting to be taken.
  typedef struct packed {
    logic               valid;
    logic signed [15:0] sample;
    logic               last;
  } vfd_res_t;

endpackage

// File: design/vadpcm_frame_decoder_unit.sv
// Top level of the VADPCM frame decoder: input and output channels, frame
// parsing, sample history, result queue and the register port.
// Depends on vfd_pkg and vfd_mac_engine.
`timescale 1ns / 1ps

// Usage:
// The input channel moves one byte-level item per transfer (in_valid/in_stall).
// func 0 loads one codebook coefficient, func 2 starts a new stream, func 1
// carries a frame byte: first the header (shift, predictor), then eight data
// bytes. Each data byte gives two samples on the output channel, the second
// marked by out_last. Loads, headers and stream starts give no result.
// A data byte holds the input stalled while the shared multiply-accumulate
// unit works: sample j of a half-frame takes j+2 codebook reads through the
// single read port, then the read and product registers drain and the
// result is handed off to the queue.
// Finished samples enter a two-entry queue, so the next item is taken while
// results still wait; when the receiver stalls and the queue is full the
// engine holds its finished sample until room appears.
// The user must write num_predictors through the cfg_ port only while the
// block is idle; the block does not enforce it. Synchronous reset clears the
// stream state and the queue; the codebook holds no defined value until loaded.

module vadpcm_frame_decoder_unit #(
  parameter int MAX_PREDICTORS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import vfd_pkg::*;

  localparam logic [4:0] MAX_PRED = 5'(MAX_PREDICTORS);

  logic [4:0]         num_pred_r;
  logic [3:0]         pos_r;
  logic [3:0]         shift_r;
  logic [3:0]         pred_r;
  logic signed [15:0] half_prev_one_r, half_prev_two_r;
  logic signed [15:0] latest_one_r, latest_two_r;

  logic signed [15:0] q_sample_r [2];
  logic               q_last_r [2];
  logic [1:0]         q_cnt_r;
  logic               q_wr_r, q_rd_r;

  vfd_ctl_t ctl;
  vfd_res_t res;
  logic     busy;
  logic     accept, is_data, is_header, is_byte;
  logic [1:0] b;
  logic [3:0] hdr_pred;
  logic     take, pop;
  logic     cfg_wr;

  function automatic logic signed [15:0] scale_nibble(input logic [3:0] nib,
                                                      input logic [3:0] sh);
    logic [15:0] ext;
    begin
      ext = {{12{nib[3]}}, nib};
      scale_nibble = ext << sh;
    end
  endfunction

  // Register port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_NUM_PRED) ? {27'd0, num_pred_r} : 32'd0;

  // Items are taken only while the MAC engine is idle.
  assign in_stall  = busy;
  assign accept    = in_valid && !in_stall;
  assign is_data   = accept && (in_func == FUNC_DATA);
  assign is_header = is_data && ((pos_r == 4'd0) || (pos_r > FRAME_DATA_BYTES));
  assign is_byte   = is_data && !is_header;
  assign b         = 2'(pos_r - 4'd1);

  // A header predictor beyond the loaded tables falls back to table zero.
  assign hdr_pred = (({1'b0, in_data_byte[3:0]} >= num_pred_r) ||
                     ({1'b0, in_data_byte[3:0]} >= MAX_PRED)) ? 4'd0 : in_data_byte[3:0];

  always_comb begin
    ctl.start    = is_byte;
    ctl.j_base   = {b, 1'b0};
    ctl.pred     = pred_r;
    // History is re-latched at the start of each half-frame.
    ctl.prev_one = (b == 2'd0) ? latest_one_r : half_prev_one_r;
    ctl.prev_two = (b == 2'd0) ? latest_two_r : half_prev_two_r;
    ctl.nib_we   = is_byte;
    ctl.pair     = b;
    ctl.nib_hi   = scale_nibble(in_data_byte[7:4], shift_r);
    ctl.nib_lo   = scale_nibble(in_data_byte[3:0], shift_r);
    ctl.cb_we    = accept && (in_func == FUNC_LOAD);
    ctl.cb_addr  = in_coef_index;
    ctl.cb_data  = in_coef_value;
  end

  vfd_mac_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res_taken (take),
    .res       (res),
    .busy      (busy)
  );

  assign take = res.valid && (q_cnt_r != 2'd2);
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pred_r      <= 5'd0;
      pos_r           <= 4'd0;
      shift_r         <= 4'd0;
      pred_r          <= 4'd0;
      half_prev_one_r <= 16'sd0;
      half_prev_two_r <= 16'sd0;
      latest_one_r    <= 16'sd0;
      latest_two_r    <= 16'sd0;
    end else begin
      if (cfg_wr && (cfg_paddr[2] == REG_NUM_PRED)) begin
        num_pred_r <= cfg_pwdata[4:0];
      end
      if (accept) begin
        case (in_func)
          FUNC_START: begin
            pos_r           <= 4'd0;
            half_prev_one_r <= 16'sd0;
            half_prev_two_r <= 16'sd0;
            latest_one_r    <= 16'sd0;
            latest_two_r    <= 16'sd0;
          end
          FUNC_DATA: begin
            if (is_header) begin
              shift_r <= in_data_byte[7:4];
              pred_r  <= hdr_pred;
              pos_r   <= 4'd1;
            end else begin
              if (b == 2'd0) begin
                half_prev_one_r <= latest_one_r;
                half_prev_two_r <= latest_two_r;
              end
              pos_r <= (pos_r >= FRAME_DATA_BYTES) ? 4'd0 : pos_r + 4'd1;
            end
          end
          default: begin
          end
        endcase
      end
      // Sample history advances as each sample leaves the engine.
      if (take) begin
        latest_two_r <= latest_one_r;
        latest_one_r <= res.sample;
      end
    end
  end

  // Two-entry result queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
    end else begin
      if (take) begin
        q_wr_r <= ~q_wr_r;
      end
      if (pop) begin
        q_rd_r <= ~q_rd_r;
      end
      case ({take, pop})
        2'b10:   q_cnt_r <= q_cnt_r + 2'd1;
        2'b01:   q_cnt_r <= q_cnt_r - 2'd1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_sample_r[q_wr_r] <= res.sample;
      q_last_r[q_wr_r]   <= res.last;
    end
  end

  assign out_valid  = (q_cnt_r != 2'd0);
  assign out_sample = q_sample_r[q_rd_r];
  assign out_last   = q_last_r[q_rd_r];

endmodule

// File: design/vfd_mac_engine.sv
// Codebook memory, half-frame nibble store and the shared multiply-accumulate
// sequencer of the VADPCM frame decoder. Depends on vfd_pkg.
`timescale 1ns / 1ps

module vfd_mac_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  vfd_pkg::vfd_ctl_t ctl,
  input  logic           res_taken,
  output vfd_pkg::vfd_res_t res,
  output logic           busy
);
  import vfd_pkg::*;

  logic [15:0]        codebook [256];
  logic [15:0]        cb_rdata_r;
  logic signed [15:0] nib_r [8];

  eng_state_t         state_r, state_nxt;
  logic [2:0]         j_r;
  logic               second_r;
  logic [3:0]         step_r;
  logic [3:0]         pred_r;
  logic signed [15:0] prev_one_r, prev_two_r;
  logic               s1_valid_r;
  logic signed [15:0] s1_op_r;
  logic               p_valid_r;
  logic signed [31:0] prod_r;
  logic signed [31:0] acc_r;

  logic               rd_en;
  logic [7:0]         rd_addr;
  logic [3:0]         pos;
  logic [3:0]         k_idx;
  logic signed [15:0] op;
  logic               last_issue;
  logic [2:0]         j_next;
  logic signed [20:0] acc_sh;

  // Codebook: one write port for loads, one registered read port for the MAC.
  always_ff @(posedge clk) begin
    if (ctl.cb_we) begin
      codebook[ctl.cb_addr] <= ctl.cb_data;
    end
    if (rd_en) begin
      cb_rdata_r <= codebook[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.nib_we) begin
      nib_r[{ctl.pair, 1'b0}] <= ctl.nib_hi;
      nib_r[{ctl.pair, 1'b1}] <= ctl.nib_lo;
    end
  end

  assign last_issue = (step_r == ({1'b0, j_r} + 4'd1));
  assign j_next     = j_r + 3'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_IDLE:  if (ctl.start) state_nxt = E_RUN;
      E_RUN:   if (last_issue) state_nxt = E_DRAIN;
      E_DRAIN: if (!s1_valid_r && !p_valid_r) state_nxt = E_DONE;
      E_DONE:  if (res_taken) state_nxt = second_r ? E_IDLE : E_RUN;
      default: state_nxt = E_IDLE;
    endcase
  end

  // Step 0 pairs tbl0[j] with prev2, step 1 tbl1[j] with prev1, and step
  // k+2 pairs tbl1[j-k-1] with nibble k.
  always_comb begin
    rd_en = (state_r == E_RUN);
    k_idx = step_r - 4'd2;
    if (step_r == 4'd0) begin
      pos = {1'b0, j_r};
      op  = prev_two_r;
    end else if (step_r == 4'd1) begin
      pos = 4'd8 + {1'b0, j_r};
      op  = prev_one_r;
    end else begin
      pos = 4'd9 + {1'b0, j_r} - step_r;
      op  = nib_r[k_idx[2:0]];
    end
    rd_addr = {pred_r, pos};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= E_IDLE;
      s1_valid_r <= 1'b0;
      p_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= rd_en;
      p_valid_r  <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r <= op;
    prod_r  <= $signed(cb_rdata_r) * s1_op_r;
    if (state_r == E_IDLE && ctl.start) begin
      j_r        <= ctl.j_base;
      second_r   <= 1'b0;
      step_r     <= 4'd0;
      pred_r     <= ctl.pred;
      prev_one_r <= ctl.prev_one;
      prev_two_r <= ctl.prev_two;
      // The first nibble is written at this same edge, so take it directly.
      acc_r      <= {{5{ctl.nib_hi[15]}}, ctl.nib_hi, 11'd0};
    end else if (state_r == E_DONE && res_taken && !second_r) begin
      j_r      <= j_next;
      second_r <= 1'b1;
      step_r   <= 4'd0;
      acc_r    <= {{5{nib_r[j_next][15]}}, nib_r[j_next], 11'd0};
    end else begin
      if (rd_en) begin
        step_r <= step_r + 4'd1;
      end
      if (p_valid_r) begin
        acc_r <= acc_r + prod_r;
      end
    end
  end

  assign acc_sh = acc_r[31:11];

  always_comb begin
    res.valid = (state_r == E_DONE);
    res.last  = second_r;
    if (acc_sh > 21'sd32767) begin
      res.sample = 16'sh7FFF;
    end else if (acc_sh < -21'sd32768) begin
      res.sample = 16'sh8000;
    end else begin
      res.sample = acc_sh[15:0];
    end
  end

  assign busy = (state_r != E_IDLE);

endmodule
